// File: hdl/smfc_pkg.sv
// Shared types and constants for the SPI master FIFO controller.
package smfc_pkg;

	localparam int FifoDepth = 128;
	localparam int PtrW = $clog2(FifoDepth);
	localparam int LvlW = PtrW + 1;

	typedef enum logic [1:0] {
		FUNC_READ  = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_TICK  = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	localparam logic [3:0] REG_CONTROL  = 4'd0;
	localparam logic [3:0] REG_STATUS   = 4'd1;
	localparam logic [3:0] REG_MASK_SET = 4'd2;
	localparam logic [3:0] REG_MASK_CLR = 4'd3;
	localparam logic [3:0] REG_MASK     = 4'd4;
	localparam logic [3:0] REG_ENABLE   = 4'd5;
	localparam logic [3:0] REG_TX_DATA  = 4'd7;
	localparam logic [3:0] REG_RX_DATA  = 4'd8;

	typedef struct packed {
		logic [1:0]  func;
		logic [3:0]  reg_index;
		logic [31:0] write_data;
		logic        miso;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        sclk;
		logic        mosi;
		logic [3:0]  select_n;
		logic        irq;
	} rsp_t;

endpackage

// File: hdl/smfc_if.sv
// Valid/ready channel interfaces for requests and responses.
interface smfc_req_if;
	import smfc_pkg::*;
	logic valid;
	logic ready;
	logic [1:0]  func;
	logic [3:0]  reg_index;
	logic [31:0] write_data;
	logic        miso;
	modport source (output valid, func, reg_index, write_data, miso, input ready);
	modport sink (input valid, func, reg_index, write_data, miso, output ready);
endinterface

interface smfc_rsp_if;
	logic valid;
	logic ready;
	logic [31:0] read_data;
	logic        sclk;
	logic        mosi;
	logic [3:0]  select_n;
	logic        irq;
	modport source (output valid, read_data, sclk, mosi, select_n, irq, input ready);
	modport sink (input valid, read_data, sclk, mosi, select_n, irq, output ready);
endinterface

// File: hdl/smfc_front.sv
// Front end: accepts requests into a two-entry queue.
module smfc_front (
	input  logic           clk,
	input  logic           arst_n,
	smfc_req_if.sink       req,
	output smfc_pkg::req_t q_item,
	output logic           q_valid,
	input  logic           q_pop
);
	import smfc_pkg::*;

	req_t       buf_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign req.ready = (cnt_q != 2'd2);
	assign push = req.valid && req.ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= '{req.func, req.reg_index, req.write_data, req.miso};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

// File: hdl/smfc_back.sv
// Back end: registers, FIFOs and the serial engine, one transaction per cycle unless a stalled response holds it.
module smfc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  smfc_pkg::req_t q_item,
	input  logic           q_valid,
	output logic           q_pop,
	smfc_rsp_if.source     rsp
);
	import smfc_pkg::*;

	logic [7:0]    tx_mem [FifoDepth];
	logic [7:0]    rx_mem [FifoDepth];
	logic [14:0]   ctrl_q;
	logic [6:0]    mask_q;
	logic [1:0]    sticky_q;
	logic          en_q;
	logic [PtrW-1:0] tx_head_q, rx_head_q;
	logic [LvlW-1:0] tx_lvl_q, rx_lvl_q;
	logic [7:0]    shift_q;
	logic [2:0]    bitc_q;
	logic [6:0]    timer_q;
	logic          phase_q, busy_q, sample_q;
	logic          rvalid_q;
	logic          rx_pend_q;
	logic [31:0]   rd_mux_q;
	logic [7:0]    rx_rd_s1;
	logic [7:0]    tx_rd_s1;

	logic go, is_rd, is_wr, is_tick;
	logic tx_push, rx_pop, load, rx_push, halt;
	logic [6:0] half_m1;
	logic [6:0] status;
	logic [PtrW-1:0] tx_wa, rx_wa, tx_rd_addr;
	logic [7:0] shifted, new_shift;
	logic byte_end;
	logic [31:0] rd_mux;

	assign q_pop = q_valid && (!rvalid_q || rsp.ready);
	assign go = q_pop;
	assign is_rd = go && (q_item.func == FUNC_READ);
	assign is_wr = go && (q_item.func == FUNC_WRITE);
	assign is_tick = go && (q_item.func == FUNC_TICK);
	assign half_m1 = 7'((8'd1 << ctrl_q[5:3]) - 8'd1);
	assign tx_push = is_wr && q_item.reg_index == REG_TX_DATA && tx_lvl_q != LvlW'(FifoDepth);
	assign rx_pop = is_rd && q_item.reg_index == REG_RX_DATA && rx_lvl_q != '0;
	assign tx_wa = PtrW'(tx_head_q + tx_lvl_q[PtrW-1:0]);
	assign rx_wa = PtrW'(rx_head_q + rx_lvl_q[PtrW-1:0]);
	// prefetch the byte that the next load takes
	assign tx_rd_addr = load ? PtrW'(tx_head_q + 1'b1) : tx_head_q;

	// serial engine next state
	always_comb begin
		load = 1'b0;
		rx_push = 1'b0;
		halt = 1'b0;
		byte_end = 1'b0;
		// with CPHA the last bit is sampled and shifted on the same edge
		shifted = {shift_q[6:0], (phase_q && ctrl_q[2]) ? q_item.miso : sample_q};
		new_shift = shift_q;
		if (is_tick) begin
			if (!en_q || !ctrl_q[0]) halt = 1'b1;
			else if (!busy_q) load = (tx_lvl_q != '0);
			else if (timer_q == '0 && phase_q) begin
				if (!ctrl_q[2] || bitc_q == 3'd7) new_shift = shifted;
				if (bitc_q == 3'd7) begin
					byte_end = 1'b1;
					rx_push = (rx_lvl_q != LvlW'(FifoDepth));
					if (tx_lvl_q != '0) load = 1'b1;
					else halt = 1'b1;
				end
			end else if (timer_q == '0 && ctrl_q[2] && bitc_q != '0) begin
				new_shift = shifted;
			end
		end
		if (is_wr && q_item.reg_index == REG_ENABLE && !q_item.write_data[0]) halt = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (tx_push) tx_mem[tx_wa] <= q_item.write_data[7:0];
		if (tx_push && tx_wa == tx_rd_addr) tx_rd_s1 <= q_item.write_data[7:0];
		else tx_rd_s1 <= tx_mem[tx_rd_addr];
		if (rx_push) rx_mem[rx_wa] <= new_shift;
		if (rx_pop) rx_rd_s1 <= rx_mem[rx_head_q];
	end

	always_comb begin
		rd_mux = '0;
		case (q_item.reg_index)
			REG_CONTROL: rd_mux = {17'd0, ctrl_q};
			REG_STATUS:  rd_mux = {25'd0, status};
			REG_MASK:    rd_mux = {25'd0, mask_q};
			REG_ENABLE:  rd_mux = {31'd0, en_q};
			default:     rd_mux = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0; mask_q <= '0; sticky_q <= '0; en_q <= 1'b0;
			tx_head_q <= '0; rx_head_q <= '0; tx_lvl_q <= '0; rx_lvl_q <= '0;
			shift_q <= '0; bitc_q <= '0; timer_q <= '0; phase_q <= 1'b0;
			busy_q <= 1'b0; sample_q <= 1'b0; rvalid_q <= 1'b0;
			rx_pend_q <= 1'b0; rd_mux_q <= '0;
		end else begin
			rvalid_q <= go || (rvalid_q && !rsp.ready);
			if (go) begin
				rx_pend_q <= rx_pop;
				rd_mux_q <= is_rd ? rd_mux : '0;
			end
			if (is_wr) begin
				case (q_item.reg_index)
					REG_CONTROL:  ctrl_q <= q_item.write_data[14:0];
					REG_STATUS: begin
						if (q_item.write_data[0]) sticky_q[0] <= 1'b0;
						if (q_item.write_data[6]) sticky_q[1] <= 1'b0;
					end
					REG_MASK_SET: mask_q <= mask_q | q_item.write_data[6:0];
					REG_MASK_CLR: mask_q <= mask_q & ~q_item.write_data[6:0];
					REG_ENABLE:   en_q <= q_item.write_data[0];
					default: ;
				endcase
			end
			if (rx_pop) rx_head_q <= rx_head_q + 1'b1;
			rx_lvl_q <= rx_lvl_q + {{PtrW{1'b0}}, rx_push} - {{PtrW{1'b0}}, rx_pop};
			tx_lvl_q <= tx_lvl_q + {{PtrW{1'b0}}, tx_push} - {{PtrW{1'b0}}, load};
			if (byte_end && !rx_push) sticky_q[0] <= 1'b1;
			if (load) begin
				shift_q <= tx_rd_s1;
				tx_head_q <= tx_head_q + 1'b1;
				busy_q <= 1'b1; bitc_q <= '0; phase_q <= 1'b0; sample_q <= 1'b0;
				timer_q <= half_m1;
			end else begin
				shift_q <= new_shift;
				if (halt) begin
					busy_q <= 1'b0; bitc_q <= '0; timer_q <= '0; phase_q <= 1'b0;
					sample_q <= 1'b0;
				end else if (is_tick && busy_q) begin
					if (timer_q != '0) timer_q <= timer_q - 1'b1;
					else begin
						timer_q <= half_m1;
						phase_q <= ~phase_q;
						if (!phase_q && !ctrl_q[2]) sample_q <= q_item.miso;
						if (phase_q) begin
							if (ctrl_q[2]) sample_q <= q_item.miso;
							bitc_q <= bitc_q + 1'b1;
						end
					end
				end
			end
		end
	end

	assign status = {sticky_q[1], 1'b0, rx_lvl_q != '0, 1'b0, tx_lvl_q == '0, 1'b0, sticky_q[0]};
	assign rsp.valid = rvalid_q;
	assign rsp.read_data = rx_pend_q ? {24'd0, rx_rd_s1} : rd_mux_q;
	assign rsp.sclk = busy_q ? (ctrl_q[1] ^ phase_q) : ctrl_q[1];
	assign rsp.mosi = busy_q & shift_q[7];
	assign rsp.select_n = (ctrl_q[14] || busy_q) ? ctrl_q[13:10] : 4'hf;
	assign rsp.irq = |(status & mask_q);
endmodule

// File: hdl/spi_master_fifo_controller.sv
// Top level of the SPI master FIFO controller.
// One transaction (bus read, bus write or reference tick) is accepted per cycle, back to
// back, while the queue has room. A request waits in a two-entry queue and is executed by
// the register/engine back end once the response register is free; its response is
// registered and reflects state after the transaction. A response register holds a
// result while the receiver stalls; the back end pauses until it is taken and the queue
// drops ready once both entries are full. FIFOs are 128 bytes each in memories read
// through registered ports; the TX head byte is prefetched so a tick loads it at once.
// No clearing pass.
module spi_master_fifo_controller (
	input logic        clk,
	input logic        arst_n,
	smfc_req_if.sink   req,
	smfc_rsp_if.source rsp
);
	import smfc_pkg::*;

	req_t q_item;
	logic q_valid, q_pop;

	smfc_front u_front (.clk, .arst_n, .req, .q_item, .q_valid, .q_pop);
	smfc_back  u_back  (.clk, .arst_n, .q_item, .q_valid, .q_pop, .rsp);

`ifndef ASSERT_OFF
	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop of empty queue");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.read_data))
		else $error("stalled response changed");
	a_resp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> rsp.valid) else $error("response missing");
`endif
endmodule

// File: test/smfc_tb_checker.sv
// Checker for the SPI master FIFO controller: predicts each response and compares it.
module smfc_tb_checker (
	input  logic        clk,
	input  logic        arst_n,
	smfc_req_if         req,
	smfc_rsp_if         rsp,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import smfc_pkg::*;

	typedef struct packed {
		logic [31:0] read_data;
		logic        sclk;
		logic        mosi;
		logic [3:0]  select_n;
		logic        irq;
	} spi_out_t;

	logic [14:0] ctl;
	logic [6:0]  mask;
	logic [1:0]  sticky;
	logic        en;
	logic [7:0]  tx_mem [FifoDepth];
	logic [7:0]  rx_mem [FifoDepth];
	int          tx_hd, tx_lv, rx_hd, rx_lv;
	logic [7:0]  shreg;
	int          bits, timer;
	logic        phase, active, samp;
	spi_out_t    expected_q[$];

	function automatic logic [31:0] status_bits();
		logic [31:0] s;
		s = '0;
		s[0] = sticky[0];
		s[2] = (tx_lv == 0);
		s[4] = (rx_lv != 0);
		s[6] = sticky[1];
		return s;
	endfunction

	function automatic void stop_shift();
		active = 0; bits = 0; timer = 0; phase = 0; samp = 0;
	endfunction

	function automatic void start_byte();
		shreg = tx_mem[tx_hd];
		tx_hd = (tx_hd + 1) % FifoDepth;
		tx_lv--;
		active = 1; bits = 0; phase = 0; samp = 0;
		timer = (1 << ctl[5:3]) - 1;
	endfunction

	function automatic void advance_clock(logic sdi);
		if (!en || !ctl[0]) begin
			stop_shift();
			return;
		end
		if (!active) begin
			if (tx_lv != 0) start_byte();
			return;
		end
		if (timer != 0) begin
			timer--;
			return;
		end
		timer = (1 << ctl[5:3]) - 1;
		if (!phase) begin
			phase = 1;
			if (!ctl[2]) samp = sdi;
			else if (bits != 0) shreg = {shreg[6:0], samp};
			return;
		end
		phase = 0;
		if (ctl[2]) samp = sdi;
		if (!ctl[2] || bits == 7) shreg = {shreg[6:0], samp};
		bits++;
		if (bits >= 8) begin
			if (rx_lv >= FifoDepth) sticky[0] = 1;
			else begin
				rx_mem[(rx_hd + rx_lv) % FifoDepth] = shreg;
				rx_lv++;
			end
			if (tx_lv != 0) start_byte();
			else stop_shift();
		end
	endfunction

	function automatic spi_out_t predict_response(logic [1:0] f, logic [3:0] idx,
			logic [31:0] wd, logic sdi);
		spi_out_t o;
		o = '0;
		if (f == FUNC_READ) begin
			case (idx)
				REG_CONTROL: o.read_data = {17'd0, ctl};
				REG_STATUS:  o.read_data = status_bits();
				REG_MASK:    o.read_data = {25'd0, mask};
				REG_ENABLE:  o.read_data = {31'd0, en};
				REG_RX_DATA: if (rx_lv != 0) begin
					o.read_data = {24'd0, rx_mem[rx_hd]};
					rx_hd = (rx_hd + 1) % FifoDepth;
					rx_lv--;
				end
				default: ;
			endcase
		end else if (f == FUNC_WRITE) begin
			case (idx)
				REG_CONTROL: ctl = wd[14:0];
				REG_STATUS: begin
					if (wd[0]) sticky[0] = 0;
					if (wd[6]) sticky[1] = 0;
				end
				REG_MASK_SET: mask = mask | wd[6:0];
				REG_MASK_CLR: mask = mask & ~wd[6:0];
				REG_ENABLE: begin
					en = wd[0];
					if (!en) stop_shift();
				end
				REG_TX_DATA: if (tx_lv < FifoDepth) begin
					tx_mem[(tx_hd + tx_lv) % FifoDepth] = wd[7:0];
					tx_lv++;
				end
				default: ;
			endcase
		end else if (f == FUNC_TICK) begin
			advance_clock(sdi);
		end
		o.sclk = active ? (ctl[1] ^ phase) : ctl[1];
		o.mosi = active ? shreg[7] : 1'b0;
		o.select_n = (ctl[14] || active) ? ctl[13:10] : 4'hf;
		o.irq = |(status_bits() & {25'd0, mask});
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		spi_out_t e;
		int errs;
		errs = 0;
		if (!arst_n) begin
			ctl = '0; mask = '0; sticky = '0; en = 0;
			tx_hd = 0; tx_lv = 0; rx_hd = 0; rx_lv = 0; shreg = '0;
			stop_shift();
			expected_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			// check before predicting: a response never belongs to this edge's request
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected response");
					errs++;
				end else begin
					e = expected_q.pop_front();
					if (rsp.read_data !== e.read_data) begin
						$error("read_data exp %h got %h", e.read_data, rsp.read_data);
						errs++;
					end
					if (rsp.sclk !== e.sclk) begin
						$error("sclk exp %b got %b", e.sclk, rsp.sclk);
						errs++;
					end
					if (rsp.mosi !== e.mosi) begin
						$error("mosi exp %b got %b", e.mosi, rsp.mosi);
						errs++;
					end
					if (rsp.select_n !== e.select_n) begin
						$error("select_n exp %h got %h", e.select_n, rsp.select_n);
						errs++;
					end
					if (rsp.irq !== e.irq) begin
						$error("irq exp %b got %b", e.irq, rsp.irq);
						errs++;
					end
				end
			end
			if (req.valid && req.ready)
				expected_q.push_back(predict_response(req.func, req.reg_index,
					req.write_data, req.miso));
			fail_count <= fail_count + errs;
			pending <= expected_q.size();
		end
	end
endmodule

// File: test/tb_spi_master_fifo_controller.sv
// Top of the SPI master FIFO controller testbench: stimulus, stalls and verdict.
module tb_spi_master_fifo_controller;
	timeunit 1ns;
	timeprecision 1ps;
	import smfc_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count, pending;
	int   send_idle = 0, recv_stall = 0;
	bit   hold_off = 0;
	int   sent = 0, reads = 0, writes = 0, ticks = 0;

	smfc_req_if req ();
	smfc_rsp_if rsp ();

	spi_master_fifo_controller i_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	smfc_tb_checker i_chk (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.fail_count(fail_count), .pending(pending));

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	initial begin
		#20ms;
		$display("tb_spi_master_fifo_controller failed");
		$finish;
	end

	initial begin
		rsp.ready = 0;
	end

	always @(posedge clk) begin
		if (hold_off) rsp.ready <= 0;
		else rsp.ready <= ($urandom_range(99) >= recv_stall);
	end

	// drive one transaction and wait until it is accepted
	task automatic send_op(logic [1:0] f, logic [3:0] idx, logic [31:0] wd, logic sdi);
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid <= 1;
		req.func <= f;
		req.reg_index <= idx;
		req.write_data <= wd;
		req.miso <= sdi;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sent++;
		case (f)
			FUNC_READ:  reads++;
			FUNC_WRITE: writes++;
			FUNC_TICK:  ticks++;
			default: ;
		endcase
	endtask

	task automatic drain();
		req.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic random_op(int div_max);
		int r;
		r = $urandom_range(99);
		if (r < 45) send_op(FUNC_TICK, 4'($urandom), $urandom, 1'($urandom));
		else if (r < 60) send_op(FUNC_WRITE, REG_TX_DATA, $urandom, 1'($urandom));
		else if (r < 72) send_op(FUNC_READ, REG_RX_DATA, $urandom, 1'($urandom));
		else if (r < 80) send_op(FUNC_READ, 4'($urandom_range(15)), $urandom, 1'($urandom));
		else if (r < 84) send_op(FUNC_WRITE, REG_CONTROL,
			($urandom & ~32'h38) | ($urandom_range(div_max) << 3) | 1, 1'($urandom));
		else if (r < 88) send_op(FUNC_WRITE, REG_STATUS, $urandom, 1'($urandom));
		else if (r < 91) send_op(FUNC_WRITE, REG_MASK_SET, $urandom, 1'($urandom));
		else if (r < 94) send_op(FUNC_WRITE, REG_MASK_CLR, $urandom, 1'($urandom));
		else if (r < 97) send_op(FUNC_WRITE, REG_ENABLE, 32'($urandom_range(9) != 0),
			1'($urandom));
		else send_op(FUNC_WRITE, 4'($urandom_range(15)), $urandom, 1'($urandom));
	endtask

	initial begin
		int ph;
		req.valid = 0;
		req.func = FUNC_NOP;
		req.reg_index = 0;
		req.write_data = 0;
		req.miso = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: registers, extremes, empty reads, a short transfer and a mode change
		send_op(FUNC_READ, REG_RX_DATA, 0, 0);
		send_op(FUNC_READ, REG_STATUS, 0, 0);
		send_op(FUNC_WRITE, REG_MASK_SET, 32'hffff_ffff, 0);
		send_op(FUNC_READ, REG_MASK, 0, 0);
		send_op(FUNC_WRITE, REG_MASK_CLR, 32'h0000_0050, 0);
		send_op(FUNC_WRITE, REG_CONTROL, 32'hffff_ffc7, 1);
		send_op(FUNC_READ, REG_CONTROL, 0, 0);
		send_op(FUNC_WRITE, REG_CONTROL, 32'h0000_4001, 0);
		send_op(FUNC_WRITE, REG_ENABLE, 32'hffff_ffff, 0);
		send_op(FUNC_WRITE, REG_TX_DATA, 32'hffff_ffa5, 1);
		send_op(FUNC_WRITE, REG_TX_DATA, 32'h0000_0000, 0);
		repeat (40) send_op(FUNC_TICK, 0, 0, 1'($urandom));
		send_op(FUNC_WRITE, REG_CONTROL, 32'h0000_2c07, 0);
		repeat (30) send_op(FUNC_TICK, 0, 0, 1'($urandom));
		send_op(FUNC_WRITE, REG_ENABLE, 0, 0);
		send_op(FUNC_READ, REG_RX_DATA, 0, 0);
		send_op(FUNC_WRITE, REG_STATUS, 32'hffff_ffff, 0);
		send_op(FUNC_WRITE, 4'd6, 32'hffff_ffff, 1);
		send_op(FUNC_READ, 4'd15, 0, 0);
		send_op(FUNC_NOP, 4'd3, 32'h1234_5678, 1);
		drain();

		// random phases with different idling, receiver stalls and divisor ranges
		for (ph = 0; ph < 4; ph++) begin
			send_idle  = (ph == 1 || ph == 3) ? ((ph == 1) ? 64 : 12) : 0;
			recv_stall = (ph == 2) ? 64 : ((ph == 3) ? 12 : 0);
			send_op(FUNC_WRITE, REG_ENABLE, 1, 0);
			repeat (200) random_op(ph == 3 ? 7 : 1);
			drain();
		end

		// fill TX past full, stall the receiver while ticks keep coming, read RX back
		send_idle = 0;
		recv_stall = 0;
		send_op(FUNC_WRITE, REG_CONTROL, 32'h0000_0001, 0);
		send_op(FUNC_WRITE, REG_ENABLE, 0, 0);
		repeat (130) send_op(FUNC_WRITE, REG_TX_DATA, $urandom, 0);
		send_op(FUNC_WRITE, REG_ENABLE, 1, 0);
		hold_off = 1;
		fork
			repeat (200) send_op(FUNC_TICK, 0, 0, 1'($urandom));
			begin
				repeat (150) @(posedge clk);
				hold_off = 0;
			end
		join
		repeat (150) send_op(FUNC_TICK, 0, 0, 1'($urandom));
		send_op(FUNC_READ, REG_STATUS, 0, 0);
		repeat (20) send_op(FUNC_READ, REG_RX_DATA, 0, 0);
		send_op(FUNC_WRITE, REG_STATUS, 32'h41, 0);
		drain();

		$display("covered %0d transactions: %0d reads, %0d writes, %0d ticks",
			sent, reads, writes, ticks);
		$display("all control modes, long receiver stalls, TX full and RX empty exercised");
		if (fail_count == 0) $display("tb_spi_master_fifo_controller passed");
		else $display("tb_spi_master_fifo_controller failed");
		$finish;
	end
endmodule

// File: sim.f
hdl/smfc_pkg.sv
hdl/smfc_if.sv
hdl/smfc_front.sv
hdl/smfc_back.sv
hdl/spi_master_fifo_controller.sv
test/smfc_tb_checker.sv
test/tb_spi_master_fifo_controller.sv
